### hw/rtl/bim_pkg.sv
package bim_pkg;

	localparam int COORD_WIDTH_DEF = 16;

	// border modes; codes 6 and 7 behave as pass-through
	typedef enum logic [2:0] {
		BM_NONE       = 3'd0,
		BM_CLAMP      = 3'd1,
		BM_WRAP       = 3'd2,
		BM_REFLECT    = 3'd3,
		BM_REFLECT_NE = 3'd4,
		BM_TILE       = 3'd5
	} bim_mode_t;

	// configuration register indexes
	typedef enum logic [1:0] {
		REG_MODE        = 2'd0,
		REG_RANGE_LOW   = 2'd1,
		REG_RANGE_HIGH  = 2'd2,
		REG_TILE_PERIOD = 2'd3
	} bim_reg_t;

	localparam bim_mode_t MODE_RST = BM_CLAMP;
	localparam int TILE_PERIOD_RST = 1;

endpackage

### hw/rtl/bim_if.sv
interface bim_coord_if #(
	parameter int COORD_WIDTH = bim_pkg::COORD_WIDTH_DEF
);
	logic                          valid;
	logic                          ready;
	logic signed [COORD_WIDTH-1:0] coord;

	modport source (output valid, output coord, input ready);
	modport sink (input valid, input coord, output ready);
endinterface

interface bim_map_if #(
	parameter int COORD_WIDTH = bim_pkg::COORD_WIDTH_DEF
);
	logic                          valid;
	logic                          ready;
	logic signed [COORD_WIDTH-1:0] mapped;
	logic                          bad_range;

	modport source (output valid, output mapped, output bad_range, input ready);
	modport sink (input valid, input mapped, input bad_range, output ready);
endinterface

### hw/rtl/border_index_mapper.sv
// Channel   Dir  Protocol     Payload
// coord_ch  in   valid/ready  coord (signed COORD_WIDTH)
// map_ch    out  valid/ready  mapped (signed COORD_WIDTH), bad_range
// cfg_*     in   write only   cfg_index selects register, cfg_data value
//
// One item per cycle sustained while the output is not stalled; items pass s1, s2,
// the restoring remainder pipeline (one quotient bit per stage), then s3, s4, s5.
// Each stage moves when it is empty or the next stage moves, so bubbles
// collapse; a stalled output blocks upstream only once all stages ahead are full.
// arst_n clears valid bits and config (mode clamp, range [0,0], period 1).
module border_index_mapper #(
	parameter int COORD_WIDTH = bim_pkg::COORD_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  bim_pkg::bim_reg_t              cfg_index,
	input  logic [COORD_WIDTH-1:0]         cfg_data,
	bim_coord_if.sink                      coord_ch,
	bim_map_if.source                      map_ch
);
	import bim_pkg::*;

	localparam int W  = COORD_WIDTH;
	localparam int PW = W - 1;   // tile period width
	localparam int XW = W + 2;   // signed offsets
	localparam int MW = W + 2;   // modulus, up to 2^(W+1)
	localparam int RW = W + 1;   // partial remainder
	localparam int SW = W + 3;   // final sum before saturation
	localparam longint CMAX = (64'sd1 <<< (W - 1)) - 64'sd1;
	localparam logic signed [SW-1:0] SAT_MAX = SW'(CMAX);
	localparam logic signed [SW-1:0] SAT_MIN = SW'(-CMAX - 64'sd1);

	// configuration
	logic [2:0]            mode_q;
	logic signed [W-1:0]   lo_q;
	logic signed [W-1:0]   hi_q;
	logic [PW-1:0]         period_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_RST;
			lo_q     <= '0;
			hi_q     <= '0;
			period_q <= PW'(TILE_PERIOD_RST);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MODE:        mode_q   <= cfg_data[2:0];
				REG_RANGE_LOW:   lo_q     <= cfg_data;
				REG_RANGE_HIGH:  hi_q     <= cfg_data;
				REG_TILE_PERIOD: period_q <= cfg_data[PW-1:0];
				default: ;
			endcase
		end
	end

	// config-derived values; the user must keep config static while items are in flight, unenforced
	logic [PW-1:0]         p_eff;
	logic signed [XW-1:0]  span_m;
	logic                  bad;
	logic [MW-1:0]         div_m;

	assign p_eff  = (period_q == '0) ? PW'(1) : period_q;
	assign span_m = XW'(hi_q) - XW'(lo_q);
	assign bad    = hi_q < lo_q;

	always_comb begin
		div_m = MW'(1);
		if (!bad) begin
			case (mode_q)
				BM_WRAP:       div_m = MW'(span_m + 1);
				BM_REFLECT:    div_m = MW'(2 * (span_m + 1));
				BM_REFLECT_NE: div_m = (span_m == '0) ? MW'(1) : MW'(2 * span_m);
				BM_TILE:       div_m = MW'(p_eff);
				default:       div_m = MW'(1);
			endcase
		end
	end

	// pipeline control
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic en_s1, en_s2, en_s3, en_s4, en_s5;
	logic v_sd  [W];
	logic en_sd [W];

	assign en_s5 = !v_s5 || map_ch.ready;
	assign en_s4 = !v_s4 || en_s5;
	assign en_s3 = !v_s3 || en_s4;
	assign en_s2 = !v_s2 || en_sd[0];
	assign en_s1 = !v_s1 || en_s2;
	assign coord_ch.ready = en_s1;

	// s1: input register
	logic signed [W-1:0] a_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en_s1) begin
			v_s1 <= coord_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1 && coord_ch.valid) begin
			a_s1 <= coord_ch.coord;
		end
	end

	// s2: dividend selection and magnitude
	logic signed [XW-1:0] x_c;
	logic                 neg_c;
	logic [W-1:0]         mag_c;
	logic signed [W-1:0]  a_s2;
	logic                 neg_s2;
	logic [W-1:0]         mag_s2;

	always_comb begin
		// tile above the range measures from hi + 1, everything else from lo
		if (mode_q == BM_TILE && a_s1 > hi_q) begin
			x_c = XW'(a_s1) - XW'(hi_q) - XW'(1);
		end else begin
			x_c = XW'(a_s1) - XW'(lo_q);
		end
		neg_c = x_c < 0;
		mag_c = W'(neg_c ? -x_c : x_c);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2 && v_s1) begin
			a_s2   <= a_s1;
			neg_s2 <= neg_c;
			mag_s2 <= mag_c;
		end
	end

	// remainder pipeline: one restoring step per stage, MSB first
	logic [RW-1:0]       rem_sd [W];
	logic [W-1:0]        dvd_sd [W];
	logic signed [W-1:0] a_sd   [W];
	logic                neg_sd [W];

	for (genvar k = 0; k < W; k++) begin : g_div
		logic [RW-1:0]       rem_in;
		logic [W-1:0]        dvd_in;
		logic signed [W-1:0] a_in;
		logic                neg_in;
		logic                v_in;
		logic                en_next;
		logic [MW-1:0]       trial;
		logic [RW-1:0]       rem_nx;

		if (k == 0) begin : g_first
			assign rem_in = '0;
			assign dvd_in = mag_s2;
			assign a_in   = a_s2;
			assign neg_in = neg_s2;
			assign v_in   = v_s2;
		end else begin : g_next
			assign rem_in = rem_sd[k-1];
			assign dvd_in = dvd_sd[k-1];
			assign a_in   = a_sd[k-1];
			assign neg_in = neg_sd[k-1];
			assign v_in   = v_sd[k-1];
		end

		if (k == W - 1) begin : g_last
			assign en_next = en_s3;
		end else begin : g_mid
			assign en_next = en_sd[k+1];
		end

		assign en_sd[k] = !v_sd[k] || en_next;
		assign trial    = {rem_in, dvd_in[W-1]};
		assign rem_nx   = (trial >= div_m) ? RW'(trial - div_m) : trial[RW-1:0];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_sd[k] <= 1'b0;
			end else if (en_sd[k]) begin
				v_sd[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en_sd[k] && v_in) begin
				rem_sd[k] <= rem_nx;
				dvd_sd[k] <= {dvd_in[W-2:0], 1'b0};
				a_sd[k]   <= a_in;
				neg_sd[k] <= neg_in;
			end
		end
	end

	// s3: Euclidean correction of the remainder
	logic [MW-1:0]       e_c;
	logic [MW-1:0]       e_s3;
	logic signed [W-1:0] a_s3;

	assign e_c = (neg_sd[W-1] && rem_sd[W-1] != '0) ?
		MW'(div_m - MW'(rem_sd[W-1])) : MW'(rem_sd[W-1]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en_s3) begin
			v_s3 <= v_sd[W-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en_s3 && v_sd[W-1]) begin
			e_s3 <= e_c;
			a_s3 <= a_sd[W-1];
		end
	end

	// s4: fold and rebase per mode
	logic signed [SW-1:0] lo_x, hi_x, a_x, e_x, m_x, p_x, span_x;
	logic signed [SW-1:0] sum_c;
	logic signed [SW-1:0] sum_s4;

	assign lo_x   = SW'(lo_q);
	assign hi_x   = SW'(hi_q);
	assign a_x    = SW'(a_s3);
	assign e_x    = SW'(e_s3);
	assign m_x    = SW'(div_m);
	assign p_x    = SW'(p_eff);
	assign span_x = hi_x - lo_x;

	always_comb begin
		case (mode_q)
			BM_CLAMP: begin
				sum_c = (a_x < lo_x) ? lo_x : ((a_x > hi_x) ? hi_x : a_x);
			end
			BM_WRAP: begin
				sum_c = e_x + lo_x;
			end
			BM_REFLECT: begin
				// second half of the 2r period mirrors with the edge repeated
				sum_c = ((e_x <= span_x) ? e_x : (m_x - SW'(1) - e_x)) + lo_x;
			end
			BM_REFLECT_NE: begin
				if (span_x == '0) begin
					sum_c = lo_x;
				end else begin
					sum_c = ((e_x <= span_x) ? e_x : (m_x - e_x)) + lo_x;
				end
			end
			BM_TILE: begin
				if (a_x < lo_x) begin
					sum_c = e_x + lo_x;
				end else if (a_x > hi_x) begin
					sum_c = e_x + hi_x + SW'(1) - p_x;
				end else begin
					sum_c = a_x;
				end
			end
			default: begin
				sum_c = a_x;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en_s4) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s4 && v_s3) begin
			sum_s4 <= sum_c;
		end
	end

	// s5: saturation, inverted range override, output register
	logic signed [W-1:0] mapped_c;
	logic signed [W-1:0] mapped_s5;
	logic                bad_s5;

	always_comb begin
		if (bad) begin
			mapped_c = lo_q;
		end else if (sum_s4 > SAT_MAX) begin
			mapped_c = W'(SAT_MAX);
		end else if (sum_s4 < SAT_MIN) begin
			mapped_c = W'(SAT_MIN);
		end else begin
			mapped_c = W'(sum_s4);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (en_s5) begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s5 && v_s4) begin
			mapped_s5 <= mapped_c;
			bad_s5    <= bad;
		end
	end

	assign map_ch.valid     = v_s5;
	assign map_ch.mapped    = mapped_s5;
	assign map_ch.bad_range = bad_s5;

endmodule

### sim/tb_border_index_mapper.sv
module tb_border_index_mapper;
	import bim_pkg::*;

	localparam int CW = COORD_WIDTH_DEF;
	localparam int MAP_LATENCY = CW + 5;
	localparam int RANDOM_ITEMS = 1800;
	localparam int CYCLE_LIMIT = 200000;
	localparam longint COORD_MAX = (longint'(1) <<< (CW - 1)) - 1;
	localparam longint COORD_MIN = -COORD_MAX - 1;
	localparam logic [2:0] MODE_UNUSED6 = 3'd6;
	localparam logic [2:0] MODE_UNUSED7 = 3'd7;
	localparam int N_DIRECTED = 26;

	typedef struct packed {
		logic signed [CW-1:0] mapped;
		logic                 bad;
	} map_res_t;

	typedef struct packed {
		logic [2:0] mode;
		int         lo;
		int         hi;
		int         period;
		int         coord;
		bit         typed;
		int         mapped;
		bit         bad;
	} dir_row_t;

	logic          clk = 1'b0;
	logic          arst_n;
	logic          cfg_we;
	bim_reg_t      cfg_index;
	logic [CW-1:0] cfg_data;

	bim_coord_if #(.COORD_WIDTH(CW)) coord_ch ();
	bim_map_if #(.COORD_WIDTH(CW)) map_ch ();

	border_index_mapper #(.COORD_WIDTH(CW)) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.coord_ch (coord_ch),
		.map_ch   (map_ch)
	);

	// register copies used by the predictor
	logic [2:0]           cur_mode;
	logic signed [CW-1:0] cur_low;
	logic signed [CW-1:0] cur_high;
	logic [CW-2:0]        cur_period;

	map_res_t expected_maps [$];

	int  cycles = 0;
	int  mismatches = 0;
	int  results_seen = 0;
	int  items_sent = 0;
	int  directed_items = 0;
	int  settings_used = 0;
	bit  steady = 1'b0;

	// mode, lo, hi, period, coord, typed, mapped, bad
	dir_row_t dir_rows [N_DIRECTED] = '{
		// reset values: clamp to [0,0]
		'{BM_CLAMP, 0, 0, 1, 100, 1'b1, 0, 1'b0},
		'{BM_CLAMP, 0, 0, 1, -32768, 1'b1, 0, 1'b0},
		'{BM_CLAMP, -10, 20, 1, -32768, 1'b1, -10, 1'b0},
		'{BM_CLAMP, -10, 20, 1, 32767, 1'b1, 20, 1'b0},
		'{BM_CLAMP, -10, 20, 1, 5, 1'b1, 5, 1'b0},
		'{BM_NONE, -10, 20, 1, -32768, 1'b1, -32768, 1'b0},
		'{BM_NONE, -10, 20, 1, 32767, 1'b1, 32767, 1'b0},
		'{BM_WRAP, 0, 9, 1, -1, 1'b1, 9, 1'b0},
		'{BM_WRAP, 0, 9, 1, 25, 1'b0, 0, 1'b0},
		'{BM_WRAP, -32768, 32767, 1, -32768, 1'b0, 0, 1'b0},
		'{BM_REFLECT, 0, 9, 1, -1, 1'b0, 0, 1'b0},
		'{BM_REFLECT, 0, 9, 1, 12, 1'b0, 0, 1'b0},
		// single-point range without edge repeat
		'{BM_REFLECT_NE, 5, 5, 1, 1000, 1'b1, 5, 1'b0},
		'{BM_REFLECT_NE, 0, 9, 1, -3, 1'b0, 0, 1'b0},
		'{BM_REFLECT_NE, 0, 9, 1, 14, 1'b0, 0, 1'b0},
		'{BM_TILE, 0, 9, 4, 3, 1'b1, 3, 1'b0},
		'{BM_TILE, 0, 9, 4, -5, 1'b0, 0, 1'b0},
		'{BM_TILE, 0, 9, 4, 15, 1'b0, 0, 1'b0},
		// bit 15 is dropped, so the period register reads zero
		'{BM_TILE, 0, 9, 32768, -3, 1'b0, 0, 1'b0},
		'{BM_TILE, 0, 9, 32768, 12, 1'b0, 0, 1'b0},
		// tile results past both ends saturate
		'{BM_TILE, 32000, 32767, 32767, 31999, 1'b1, 32767, 1'b0},
		'{BM_TILE, -32768, -32768, 32767, -32767, 1'b1, -32768, 1'b0},
		'{BM_WRAP, 10, -10, 1, 0, 1'b1, 10, 1'b1},
		'{MODE_UNUSED7, 10, -10, 1, 0, 1'b1, 10, 1'b1},
		'{MODE_UNUSED6, 0, 9, 1, -500, 1'b1, -500, 1'b0},
		'{MODE_UNUSED7, 0, 9, 1, 32767, 1'b1, 32767, 1'b0}
	};

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic longint floor_mod(longint x, longint m);
		longint r;
		r = x % m;
		if (r < 0)
			r += m;
		return r;
	endfunction

	function automatic logic signed [CW-1:0] clip_coord(longint v);
		if (v > COORD_MAX)
			v = COORD_MAX;
		else if (v < COORD_MIN)
			v = COORD_MIN;
		return v[CW-1:0];
	endfunction

	function automatic map_res_t predict_map(logic signed [CW-1:0] c);
		longint   a, lo, hi, p, span, e, v;
		map_res_t res;
		a = c;
		lo = cur_low;
		hi = cur_high;
		if (cur_period == 0)
			p = 1;
		else
			p = longint'(cur_period);
		res.bad = 1'b0;
		if (hi < lo) begin
			res.mapped = cur_low;
			res.bad = 1'b1;
			return res;
		end
		case (cur_mode)
			BM_CLAMP: v = (a < lo) ? lo : ((a > hi) ? hi : a);
			BM_WRAP: v = floor_mod(a - lo, hi - lo + 1) + lo;
			BM_REFLECT: begin
				span = hi - lo + 1;
				e = floor_mod(a - lo, 2 * span);
				v = ((e < span) ? e : 2 * span - 1 - e) + lo;
			end
			BM_REFLECT_NE: begin
				span = hi - lo;
				if (span == 0) begin
					v = lo;
				end else begin
					e = floor_mod(a - lo, 2 * span);
					v = ((e <= span) ? e : 2 * span - e) + lo;
				end
			end
			BM_TILE: begin
				if (a < lo)
					v = floor_mod(a - lo, p) + lo;
				else if (a > hi)
					v = floor_mod(a - hi - 1, p) + hi + 1 - p;
				else
					v = a;
			end
			default: v = a;
		endcase
		res.mapped = clip_coord(v);
		return res;
	endfunction

	// mostly narrow ranges anywhere in the window, some at its edges, some inverted
	task automatic pick_setting(output logic [2:0] m, output logic [CW-1:0] lo,
			output logic [CW-1:0] hi, output logic [CW-1:0] pd);
		longint l, h, w;
		int     pick;
		if ($urandom_range(0, 99) < 88)
			m = 3'($urandom_range(BM_NONE, BM_TILE));
		else
			m = 3'($urandom_range(MODE_UNUSED6, MODE_UNUSED7));
		w = 1;
		pick = $urandom_range(0, 99);
		if (pick < 85) begin
			if (pick < 60)
				w = $urandom_range(1, 40);
			else if (pick < 75)
				w = $urandom_range(41, 3000);
			else if (pick < 80)
				w = 1;
			else
				w = COORD_MAX - COORD_MIN + 1;
			l = longint'($urandom_range(0, 65535)) + COORD_MIN;
			if ($urandom_range(0, 9) == 0)
				l = COORD_MIN;
			h = l + w - 1;
			if (h > COORD_MAX || $urandom_range(0, 9) == 0) begin
				h = COORD_MAX;
				l = h - w + 1;
			end
		end else begin
			l = COORD_MIN + 1 + longint'($urandom_range(0, 65534));
			h = l - 1 - longint'($urandom_range(0, l - 1 - COORD_MIN));
		end
		lo = l[CW-1:0];
		hi = h[CW-1:0];
		pick = $urandom_range(0, 99);
		if (pick < 55)
			pd = CW'($urandom_range(1, 16));
		else if (pick < 75)
			pd = CW'($urandom_range(1, (2 * w + 2 > 32767) ? 32767 : 2 * w + 2));
		else if (pick < 88)
			pd = CW'($urandom());
		else if (pick < 94)
			pd = CW'(COORD_MAX);
		else
			pd = {$urandom_range(0, 1) == 1, {(CW-1){1'b0}}};
	endtask

	function automatic logic signed [CW-1:0] pick_coord();
		longint lo, hi, w;
		int     pick;
		lo = cur_low;
		hi = cur_high;
		w = (hi >= lo) ? hi - lo + 1 : 16;
		pick = $urandom_range(0, 99);
		if (pick < 60)
			return clip_coord(lo - 2 * w - 3 + longint'($urandom_range(0, 4 * w + 6)));
		if (pick < 85)
			return CW'($urandom());
		case ($urandom_range(0, 7))
			0: return clip_coord(COORD_MIN);
			1: return clip_coord(COORD_MAX);
			2: return clip_coord(lo);
			3: return clip_coord(hi);
			4: return clip_coord(lo - 1);
			5: return clip_coord(hi + 1);
			6: return clip_coord(0);
			default: return clip_coord(-1);
		endcase
	endfunction

	// leaves cfg_we high; the caller lowers it after the last write
	task automatic write_reg(input bim_reg_t idx, input logic [CW-1:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		case (idx)
			REG_MODE: cur_mode = value[2:0];
			REG_RANGE_LOW: cur_low = value;
			REG_RANGE_HIGH: cur_high = value;
			default: cur_period = value[CW-2:0];
		endcase
	endtask

	task automatic apply_setting(input logic [2:0] m, input logic [CW-1:0] lo,
			input logic [CW-1:0] hi, input logic [CW-1:0] pd);
		coord_ch.valid <= 1'b0;
		while (expected_maps.size() != 0)
			@(posedge clk);
		write_reg(REG_MODE, {{(CW-3){1'b0}}, m});
		write_reg(REG_RANGE_LOW, lo);
		write_reg(REG_RANGE_HIGH, hi);
		write_reg(REG_TILE_PERIOD, pd);
		cfg_we <= 1'b0;
		settings_used++;
	endtask

	// returns in the step of acceptance; valid is left high for the next call
	task automatic push_coord(input logic signed [CW-1:0] c, input bit typed,
			input map_res_t typed_res);
		while (!steady && $urandom_range(0, 99) < 20) begin
			coord_ch.valid <= 1'b0;
			@(posedge clk);
		end
		coord_ch.valid <= 1'b1;
		coord_ch.coord <= c;
		do
			@(posedge clk);
		while (!coord_ch.ready);
		expected_maps.push_back(typed ? typed_res : predict_map(c));
		items_sent++;
	endtask

	always @(posedge clk) begin : result_check
		map_res_t want;
		if (arst_n) begin
			if (map_ch.valid && map_ch.ready) begin
				results_seen++;
				if (expected_maps.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("ERROR: unexpected result mapped=%0d bad_range=%0b",
							map_ch.mapped, map_ch.bad_range);
				end else begin
					want = expected_maps.pop_front();
					if (map_ch.mapped !== want.mapped || map_ch.bad_range !== want.bad) begin
						mismatches++;
						if (mismatches <= 10)
							$display("ERROR result %0d: expected %0d/%0b, got %0d/%0b",
								results_seen, want.mapped, want.bad,
								map_ch.mapped, map_ch.bad_range);
					end
				end
			end
			map_ch.ready <= steady || ($urandom_range(0, 99) >= 20);
		end else begin
			map_ch.ready <= 1'b0;
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin : stimulus
		dir_row_t      row;
		map_res_t      typed_res;
		logic [2:0]    m;
		logic [CW-1:0] lo, hi, pd;
		int            left;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_MODE;
		cfg_data = '0;
		coord_ch.valid = 1'b0;
		coord_ch.coord = '0;
		cur_mode = MODE_RST;
		cur_low = '0;
		cur_high = '0;
		cur_period = TILE_PERIOD_RST;
		typed_res = '0;
		repeat (10) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			row = dir_rows[i];
			lo = row.lo[CW-1:0];
			hi = row.hi[CW-1:0];
			pd = row.period[CW-1:0];
			if (row.mode != cur_mode || lo != cur_low || hi != cur_high ||
					pd[CW-2:0] != cur_period)
				apply_setting(row.mode, lo, hi, pd);
			typed_res.mapped = row.mapped[CW-1:0];
			typed_res.bad = row.bad;
			push_coord(row.coord[CW-1:0], row.typed, typed_res);
		end
		directed_items = items_sent;

		while (items_sent - directed_items < RANDOM_ITEMS) begin
			pick_setting(m, lo, hi, pd);
			apply_setting(m, lo, hi, pd);
			left = $urandom_range(20, 90);
			repeat (left) begin
				// one long stretch with both sides running flat out
				steady = (items_sent - directed_items) inside {[700:999]};
				push_coord(pick_coord(), 1'b0, typed_res);
			end
		end

		coord_ch.valid <= 1'b0;
		steady = 1'b0;
		while (expected_maps.size() != 0)
			@(posedge clk);
		repeat (4 * MAP_LATENCY) @(posedge clk);

		$display("Checked %0d results for %0d items (%0d directed) over %0d register settings:",
			results_seen, items_sent, directed_items, settings_used);
		$display("all border modes, unused mode codes, inverted ranges, zero period, saturation.");
		if (mismatches == 0 && expected_maps.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
